### rtl/gn3_pkg.sv
//------------------------------------------------------------------------------
// gn3_pkg
// Shared types, constants and fixed-point helpers for the 3D gradient noise.
//------------------------------------------------------------------------------
package gn3_pkg;
    localparam int TableSize = 256;
    localparam int IdxW      = 8;
    localparam int FracBits  = 16;
    localparam int ValW      = 40;
    localparam int MulW      = 24;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef logic signed [ValW-1:0] t_val;

    typedef struct packed {
        logic        kind;
        logic [7:0]  table_index;
        logic [7:0]  table_value;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } t_in;

    typedef struct packed {
        logic [17:0] noise_value;
    } t_out;

    // Signed product with FracBits fraction bits, rounded half away from zero.
    // The first operand is always a fraction or a fade value, which fits MulW bits.
    function automatic t_val qmul(input t_val a, input t_val b);
        logic [MulW-1:0]      ma;
        logic [ValW-1:0]      mb;
        logic [ValW+MulW-1:0] p;
        logic [ValW-1:0]      r;
        logic                 ng;
        begin
            ng = a[ValW-1] ^ b[ValW-1];
            ma = a[ValW-1] ? MulW'(~a + 1'b1) : MulW'(a);
            mb = b[ValW-1] ? (~b + 1'b1) : b;
            p  = ma * mb + ((ValW+MulW)'(1) << (FracBits - 1));
            r  = p[FracBits +: ValW];
            qmul = ng ? t_val'(~r + 1'b1) : t_val'(r);
        end
    endfunction

    function automatic t_val grad(input logic [3:0] h, input t_val x, input t_val y,
                                  input t_val z);
        t_val u;
        t_val v;
        begin
            u = (h < 4'd8) ? x : y;
            v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
            grad = (h[0] ? -u : u) + (h[1] ? -v : v);
        end
    endfunction
endpackage

### rtl/gn3_if.sv
//------------------------------------------------------------------------------
// gn3_if
// Valid/ready channel carrying one payload.
//------------------------------------------------------------------------------
interface gn3_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/gn3_ram.sv
//------------------------------------------------------------------------------
// gn3_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
module gn3_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/gn3_perm.sv
//------------------------------------------------------------------------------
// gn3_perm
// Permutation table: memory plus a clearing pass that loads the identity.
//------------------------------------------------------------------------------
module gn3_perm import gn3_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  logic [IdxW-1:0] i_waddr,
    input  logic [7:0]      i_wdata,
    input  logic [IdxW-1:0] i_raddr,
    output logic [7:0]      o_rdata,
    output logic            o_busy
);
    logic [IdxW:0]   r_clr;
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [7:0]      wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (!r_clr[IdxW]) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign o_busy = !r_clr[IdxW];
    assign we     = o_busy || i_we;
    assign waddr  = o_busy ? r_clr[IdxW-1:0] : i_waddr;
    assign wdata  = o_busy ? 8'(r_clr[IdxW-1:0]) : i_wdata;

    gn3_ram #(.Width(8), .Depth(TableSize)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_raddr),
        .o_rdata (o_rdata)
    );
endmodule

### rtl/gn3_core.sv
//------------------------------------------------------------------------------
// gn3_core
// Sequencer: forwards table loads; evaluates fade, corner hashes, then blends.
//------------------------------------------------------------------------------
module gn3_core import gn3_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_busy,
    gn3_if.sink             s_in,
    gn3_if.source           m_out,
    output logic            o_we,
    output logic [IdxW-1:0] o_waddr,
    output logic [7:0]      o_wdata,
    output logic [IdxW-1:0] o_raddr,
    input  logic [7:0]      i_rdata
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FADE = 3'd1;
    localparam logic [2:0] S_HASH = 3'd2;
    localparam logic [2:0] S_MIX  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [2:0]      r_cnr;
    logic [1:0]      r_lvl;
    logic            r_pend;
    logic [3:0]      r_mix;
    logic [4:0]      r_fs;
    logic [IdxW-1:0] r_xi, r_yi, r_zi, r_acc;
    t_val            r_f [3];
    t_val            r_fd [3];
    t_val            r_t0, r_t1, r_t2;
    t_val            r_g [8];
    logic [17:0]     r_res;
    logic            r_ov;

    logic [IdxW-1:0] ci_x, ci_y, ci_z, base;
    t_val            gx, gy, gz, val, mg, rnd;
    logic [1:0]      fi;

    assign s_in.ready   = (r_state == S_IDLE) && !i_busy;
    assign m_out.valid  = r_ov;
    assign m_out.data   = r_res;
    assign o_we         = s_in.valid && s_in.ready && (s_in.data.kind == KIND_LOAD);
    assign o_waddr      = s_in.data.table_index;
    assign o_wdata      = s_in.data.table_value;

    assign ci_x = r_xi + IdxW'(r_cnr[0]);
    assign ci_y = r_yi + IdxW'(r_cnr[1]);
    assign ci_z = r_zi + IdxW'(r_cnr[2]);

    always_comb begin
        case (r_lvl)
            2'd0:    base = ci_x;
            2'd1:    base = r_acc + ci_y;
            default: base = r_acc + ci_z;
        endcase
    end
    assign o_raddr = base;

    assign gx = r_cnr[0] ? r_f[0] - (t_val'(1) <<< FracBits) : r_f[0];
    assign gy = r_cnr[1] ? r_f[1] - (t_val'(1) <<< FracBits) : r_f[1];
    assign gz = r_cnr[2] ? r_f[2] - (t_val'(1) <<< FracBits) : r_f[2];
    assign fi = 2'(r_fs[4:3]);

    function automatic t_val frac_of(input logic [31:0] p);
        logic [31:0] m;
        logic [31:0] fr;
        begin
            m  = p[31] ? (~p + 1'b1) : p;
            fr = m & ((32'd1 << FracBits) - 32'd1);
            frac_of = p[31] ? -t_val'(fr) : t_val'(fr);
        end
    endfunction

    function automatic logic [IdxW-1:0] int_of(input logic [31:0] p);
        logic [31:0] m;
        logic [31:0] ip;
        begin
            m  = p[31] ? (~p + 1'b1) : p;
            ip = m >> FracBits;
            int_of = p[31] ? IdxW'(~ip + 1'b1) : IdxW'(ip);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_out.valid && m_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_in.valid && s_in.ready && s_in.data.kind == KIND_EVAL) begin
                        r_xi   <= int_of(s_in.data.pos_x);
                        r_yi   <= int_of(s_in.data.pos_y);
                        r_zi   <= int_of(s_in.data.pos_z);
                        r_f[0] <= frac_of(s_in.data.pos_x);
                        r_f[1] <= frac_of(s_in.data.pos_y);
                        r_f[2] <= frac_of(s_in.data.pos_z);
                        r_fs   <= '0;
                    end
                end
                S_FADE: begin
                    // Four steps per axis: t*t, t^3, t*(6t-15)+10, product.
                    case (r_fs[2:0])
                        3'd0: r_t0 <= qmul(r_f[fi], r_f[fi]);
                        3'd1: r_t0 <= qmul(r_t0, r_f[fi]);
                        3'd2: r_t1 <= qmul(r_f[fi], r_f[fi] * 6
                                    - (t_val'(15) <<< FracBits))
                                    + (t_val'(10) <<< FracBits);
                        default: r_fd[fi] <= qmul(r_t0, r_t1);
                    endcase
                    if (r_fs[2:0] == 3'd3) begin
                        r_fs <= {r_fs[4:3] + 2'd1, 3'd0};
                    end else begin
                        r_fs <= r_fs + 5'd1;
                    end
                    if (r_fs == {2'd2, 3'd3}) begin
                        r_cnr  <= '0;
                        r_lvl  <= '0;
                        r_pend <= 1'b0;
                    end
                end
                S_HASH: begin
                    // Each lookup presents the address, then takes the data from the RAM.
                    if (!r_pend) begin
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        r_acc  <= i_rdata;
                        if (r_lvl != 2'd2) begin
                            r_lvl <= r_lvl + 2'd1;
                        end else begin
                            r_g[r_cnr] <= grad(i_rdata[3:0], gx, gy, gz);
                            r_lvl <= '0;
                            r_cnr <= r_cnr + 3'd1;
                            r_mix <= '0;
                        end
                    end
                end
                S_MIX: begin
                    // Lerp tree, one product per cycle.
                    case (r_mix)
                        4'd0: r_g[0] <= r_g[0] + qmul(r_fd[0], r_g[1] - r_g[0]);
                        4'd1: r_g[2] <= r_g[2] + qmul(r_fd[0], r_g[3] - r_g[2]);
                        4'd2: r_g[4] <= r_g[4] + qmul(r_fd[0], r_g[5] - r_g[4]);
                        4'd3: r_g[6] <= r_g[6] + qmul(r_fd[0], r_g[7] - r_g[6]);
                        4'd4: r_g[0] <= r_g[0] + qmul(r_fd[1], r_g[2] - r_g[0]);
                        4'd5: r_g[4] <= r_g[4] + qmul(r_fd[1], r_g[6] - r_g[4]);
                        default: r_t2 <= r_g[0] + qmul(r_fd[2], r_g[4] - r_g[0])
                                         + (t_val'(1) <<< FracBits);
                    endcase
                    r_mix <= r_mix + 4'd1;
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_res <= rnd[17:0];
                        r_ov  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // (v+1)/2 with FracBits fraction bits equals v+1 rounded by one bit.
    always_comb begin
        val = r_t2;
        mg  = val[ValW-1] ? -val : val;
        mg  = (mg + t_val'(1)) >>> 1;
        if (mg > t_val'(131072)) begin
            mg = t_val'(131072);
        end
        rnd = val[ValW-1] ? -mg : mg;
        if (rnd > t_val'(131071)) begin
            rnd = t_val'(131071);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_in.valid && s_in.ready && s_in.data.kind == KIND_EVAL) begin
                n_state = S_FADE;
            end
            S_FADE: if (r_fs == {2'd2, 3'd3}) begin
                n_state = S_HASH;
            end
            S_HASH: if (r_pend && r_lvl == 2'd2 && r_cnr == 3'd7) begin
                n_state = S_MIX;
            end
            S_MIX: if (r_mix == 4'd6) begin
                n_state = S_OUT;
            end
            S_OUT: if (r_ov && m_out.ready) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### rtl/gradient_noise_3d.sv
//------------------------------------------------------------------------------
// gradient_noise_3d
// Three-dimensional improved gradient noise in fixed point.
//------------------------------------------------------------------------------
// Usage: items arrive on s_in, results leave on m_out, both valid/ready.
// A load transaction (kind 0) writes one permutation byte and returns nothing;
// it is written as it is accepted. An evaluate transaction (kind 1) takes a
// Q15.16 point and returns one Q1.16 noise value.
// After an evaluate is accepted, the block computes the three fade
// polynomials, makes 24 table reads (3 lookups times 8 corners) through
// the single table read port, does 7 lerps and then registers the result
// in its output state. The table memory with its one read port sets the
// hashing time. One item is in flight.
// After reset the table is rewritten with the identity in all 256 entries,
// during which no transaction is accepted.
// The result sits in an output register; a stalled receiver holds the block
// in its output state until the result is taken, then the next item enters.
//------------------------------------------------------------------------------
module gradient_noise_3d import gn3_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    gn3_if.sink   s_in,
    gn3_if.source m_out
);
    logic            we, busy;
    logic [IdxW-1:0] waddr, raddr;
    logic [7:0]      wdata, rdata;

    gn3_perm u_perm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata),
        .o_busy  (busy)
    );

    gn3_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_busy  (busy),
        .s_in    (s_in),
        .m_out   (m_out),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );
endmodule

### rtl/gn3_check.sv
//------------------------------------------------------------------------------
// gn3_check
// Port-level checks for the gradient noise block.
//------------------------------------------------------------------------------
module gn3_check import gn3_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [17:0] out_data
);
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Result dropped or changed while stalled.");
    ap_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("Input accepted while a result waits.");
    ap_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid && !in_ready)
        else $error("Block active right after reset.");
endmodule

bind gradient_noise_3d gn3_check u_check (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (s_in.ready),
    .out_valid (m_out.valid),
    .out_ready (m_out.ready),
    .out_data  (m_out.data)
);
